// ===== hdl/pfw_pkg.sv =====
package pfw_pkg;

    // Event codes carried on the result side.
    typedef enum logic [2:0] {
        EV_VARINT = 3'd0,
        EV_START  = 3'd1,
        EV_BYTE   = 3'd2,
        EV_END    = 3'd3,
        EV_STOP   = 3'd4
    } t_kind;

    // Wire types that the parser understands.
    localparam logic [2:0] WIRE_VARINT  = 3'd0;
    localparam logic [2:0] WIRE_FIXED64 = 3'd1;
    localparam logic [2:0] WIRE_LEN     = 3'd2;
    localparam logic [2:0] WIRE_FIXED32 = 3'd5;

    // Payload sizes of the fixed-width wire types.
    localparam logic [3:0] FIXED64_BYTES = 4'd8;
    localparam logic [3:0] FIXED32_BYTES = 4'd4;

    // Stop causes.
    localparam logic CAUSE_WIRE   = 1'b0;
    localparam logic CAUSE_LENGTH = 1'b1;

    // Varint decoding: 7 payload bits per byte, at most 10 groups kept.
    localparam int unsigned GROUP_BITS = 7;
    localparam int unsigned MAX_GROUPS = 10;

    // Width of the packed result tdata, rounded up to whole bytes.
    localparam int unsigned OUT_FIELD_BITS = 32 + 3 + 64 + 8 + 1;
    localparam int unsigned OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] field_id;
        logic [2:0]  wire_type;
        logic [63:0] number_value;
        logic [7:0]  payload_value;
        logic        stop_cause;
        logic        run_last;
    } t_event;

    // Up to two events caused by one input byte.
    typedef struct packed {
        logic   has;
        logic   two;
        t_event ev0;
        t_event ev1;
    } t_pair;

    function automatic t_event mk_event(
        input t_kind       kind,
        input logic [31:0] field_id,
        input logic [2:0]  wire_type,
        input logic [63:0] number_value,
        input logic [7:0]  payload_value,
        input logic        stop_cause
    );
        t_event ev;
        ev.kind          = kind;
        ev.field_id      = field_id;
        ev.wire_type     = wire_type;
        ev.number_value  = number_value;
        ev.payload_value = payload_value;
        ev.stop_cause    = stop_cause;
        ev.run_last      = 1'b0;
        return ev;
    endfunction

endpackage

// ===== hdl/pfw_decode.sv =====
module pfw_decode #(
    parameter int LENGTH_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_in_last,
    output logic           o_pair_valid,
    input  logic           i_pair_ready,
    output pfw_pkg::t_pair o_pair
);
    import pfw_pkg::*;

    typedef enum logic [2:0] {
        PH_TAG,
        PH_VALUE,
        PH_LEN,
        PH_PAYLOAD,
        PH_STOP
    } t_phase;

    localparam logic [63:0] LenMask = (LENGTH_BITS >= 64) ? {64{1'b1}} :
                                      ((64'd1 << LENGTH_BITS) - 64'd1);

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parser state.
    t_phase                 r_phase, n_phase;
    logic [63:0]            r_acc, n_acc;
    logic [3:0]             r_shift, n_shift;
    logic [31:0]            r_field, n_field;
    logic [2:0]             r_wire, n_wire;
    logic [LENGTH_BITS-1:0] r_remain, n_remain;

    logic [63:0]            acc_new;
    logic [3:0]             shift_new;
    logic                   done;
    logic [31:0]            tag_field;
    logic [2:0]             tag_wire;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic                   fire;
    t_pair                  pair;

    // Fold the current byte's 7-bit group into the accumulator.
    always_comb begin
        acc_new   = r_acc;
        shift_new = r_shift;
        for (int i = 0; i < MAX_GROUPS; i++) begin
            if (r_shift == 4'(i)) begin
                acc_new   = r_acc | (64'(r_in_byte[GROUP_BITS-1:0]) << (GROUP_BITS * i));
                shift_new = 4'(i + 1);
            end
        end
    end

    assign done       = !r_in_byte[7] || r_in_last;
    assign tag_field  = acc_new[34:3];
    assign tag_wire   = acc_new[2:0];
    assign remain_dec = r_remain - LENGTH_BITS'(1);

    // Next state and the events of the byte in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_shift  = r_shift;
        n_field  = r_field;
        n_wire   = r_wire;
        n_remain = r_remain;
        pair     = '0;

        unique case (r_phase)
            PH_TAG: begin
                n_acc   = acc_new;
                n_shift = shift_new;
                if (done) begin
                    n_acc   = '0;
                    n_shift = '0;
                    n_field = tag_field;
                    n_wire  = tag_wire;
                    if (tag_wire == WIRE_VARINT) begin
                        if (r_in_last) begin
                            pair.has = 1'b1;
                            pair.ev0 = mk_event(EV_VARINT, tag_field, tag_wire, '0, '0, 1'b0);
                        end else begin
                            n_phase = PH_VALUE;
                        end
                    end else if (tag_wire == WIRE_FIXED64 || tag_wire == WIRE_FIXED32) begin
                        pair.has = 1'b1;
                        if (r_in_last) begin
                            pair.ev0 = mk_event(EV_STOP, tag_field, tag_wire, '0, '0,
                                                CAUSE_LENGTH);
                            n_phase  = PH_STOP;
                        end else begin
                            n_remain = (tag_wire == WIRE_FIXED64) ?
                                       LENGTH_BITS'(FIXED64_BYTES) :
                                       LENGTH_BITS'(FIXED32_BYTES);
                            pair.ev0 = mk_event(EV_START, tag_field, tag_wire,
                                                (tag_wire == WIRE_FIXED64) ?
                                                64'(FIXED64_BYTES) : 64'(FIXED32_BYTES),
                                                '0, 1'b0);
                            n_phase  = PH_PAYLOAD;
                        end
                    end else if (tag_wire == WIRE_LEN) begin
                        if (r_in_last) begin
                            pair.has = 1'b1;
                            pair.two = 1'b1;
                            pair.ev0 = mk_event(EV_START, tag_field, tag_wire, '0, '0, 1'b0);
                            pair.ev1 = mk_event(EV_END, tag_field, tag_wire, '0, '0, 1'b0);
                        end else begin
                            n_phase = PH_LEN;
                        end
                    end else begin
                        pair.has = 1'b1;
                        pair.ev0 = mk_event(EV_STOP, tag_field, tag_wire, '0, '0, CAUSE_WIRE);
                        n_phase  = PH_STOP;
                    end
                end
            end
            PH_VALUE: begin
                n_acc   = acc_new;
                n_shift = shift_new;
                if (done) begin
                    n_acc    = '0;
                    n_shift  = '0;
                    pair.has = 1'b1;
                    pair.ev0 = mk_event(EV_VARINT, r_field, r_wire, acc_new, '0, 1'b0);
                    n_phase  = PH_TAG;
                end
            end
            PH_LEN: begin
                n_acc   = acc_new;
                n_shift = shift_new;
                if (done) begin
                    n_acc    = '0;
                    n_shift  = '0;
                    pair.has = 1'b1;
                    if ((acc_new & ~LenMask) != '0) begin
                        pair.ev0 = mk_event(EV_STOP, r_field, r_wire, '0, '0, CAUSE_LENGTH);
                        n_phase  = PH_STOP;
                    end else if (acc_new == '0) begin
                        pair.two = 1'b1;
                        pair.ev0 = mk_event(EV_START, r_field, r_wire, '0, '0, 1'b0);
                        pair.ev1 = mk_event(EV_END, r_field, r_wire, '0, '0, 1'b0);
                        n_phase  = PH_TAG;
                    end else if (r_in_last) begin
                        pair.ev0 = mk_event(EV_STOP, r_field, r_wire, '0, '0, CAUSE_LENGTH);
                        n_phase  = PH_STOP;
                    end else begin
                        n_remain = acc_new[LENGTH_BITS-1:0];
                        pair.ev0 = mk_event(EV_START, r_field, r_wire, acc_new, '0, 1'b0);
                        n_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                pair.has = 1'b1;
                pair.ev0 = mk_event(EV_BYTE, r_field, r_wire, '0, r_in_byte, 1'b0);
                n_remain = remain_dec;
                if (remain_dec == '0) begin
                    pair.two = 1'b1;
                    pair.ev1 = mk_event(EV_END, r_field, r_wire, '0, '0, 1'b0);
                    n_phase  = PH_TAG;
                end else if (r_in_last) begin
                    pair.two = 1'b1;
                    pair.ev1 = mk_event(EV_STOP, r_field, r_wire, '0, '0, CAUSE_LENGTH);
                    n_phase  = PH_STOP;
                end
            end
            PH_STOP: begin
                pair = '0;
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        // Mark the final event of this byte.
        pair.ev0.run_last = !pair.two;
        pair.ev1.run_last = pair.two;

        // The end of the message returns the parser to its idle state.
        if (r_in_last) begin
            n_phase  = PH_TAG;
            n_acc    = '0;
            n_shift  = '0;
            n_field  = '0;
            n_wire   = '0;
            n_remain = '0;
        end
    end

    // A byte leaves the input register once its events have room.
    assign fire         = r_in_valid && (!pair.has || i_pair_ready);
    assign o_pair_valid = r_in_valid && pair.has;
    assign o_pair       = pair;
    assign o_in_ready   = !r_in_valid || fire;

    // Input register and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_TAG;
            r_acc      <= '0;
            r_shift    <= '0;
            r_field    <= '0;
            r_wire     <= '0;
            r_remain   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_phase  <= n_phase;
                r_acc    <= n_acc;
                r_shift  <= n_shift;
                r_field  <= n_field;
                r_wire   <= n_wire;
                r_remain <= n_remain;
            end
        end
    end

    // Input payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

endmodule

// ===== hdl/pfw_out_queue.sv =====
module pfw_out_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_pair_valid,
    output logic                               o_pair_ready,
    input  pfw_pkg::t_pair                     i_pair,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [pfw_pkg::OUT_DATA_BITS-1:0]  o_m_axis_tdata,
    output logic [2:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);
    import pfw_pkg::*;

    localparam int unsigned PadBits = OUT_DATA_BITS - OUT_FIELD_BITS;

    t_pair      r_ent [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       r_sub;

    t_pair  head;
    t_event ev;
    logic   out_fire;
    logic   pop;
    logic   push;

    // Select the event at the head of the queue.
    assign head     = r_ent[r_rd_ptr];
    assign ev       = r_sub ? head.ev1 : head.ev0;
    assign out_fire = o_m_axis_tvalid && i_m_axis_tready;
    assign pop      = out_fire && (r_sub == head.two);
    assign push     = i_pair_valid && o_pair_ready;

    assign o_pair_ready    = (r_count != 2'd2) || pop;
    assign o_m_axis_tvalid = (r_count != 2'd0);
    assign o_m_axis_tuser  = ev.kind;
    assign o_m_axis_tlast  = ev.run_last;
    assign o_m_axis_tdata  = {{PadBits{1'b0}}, ev.stop_cause, ev.payload_value,
                              ev.number_value, ev.wire_type, ev.field_id};

    // Pointers, fill count and the event index within the head pair.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (out_fire) begin
                r_sub <= 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ent[r_wr_ptr] <= i_pair;
        end
    end

endmodule

// ===== hdl/protobuf_wire_field_parser.sv =====
// Channel   Dir  Group              Item
// input     in   s_axis (tdata 8)   one message byte, tlast on the final byte
// result    out  m_axis (tdata 112) one wire event, tuser event kind, tlast on
//                                   the last event of a byte
//
// One byte is accepted every cycle while each byte gives at most one event and
// the result port is ready. A byte that gives two events (field start and end,
// payload byte and field end or stop) takes two transfers on the result port;
// a two-entry queue of per-byte event pairs sits between the decoder and the
// result port. A byte's events reach the port via the input register and queue.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled result port fills the queue and then backs up into the input.
module protobuf_wire_field_parser #(
    parameter int LENGTH_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // data_byte
    input  logic                              i_s_axis_tlast,  // end_of_message
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // field_id[31:0], wire_type[34:32], number_value[98:35],
    // payload_value[106:99], stop_cause[107], zero pad[111:108]
    output logic [pfw_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata,
    output logic [2:0]                        o_m_axis_tuser,  // event_kind
    output logic                              o_m_axis_tlast   // run_last
);
    import pfw_pkg::*;

    logic  pair_valid;
    logic  pair_ready;
    t_pair pair;

    // Byte decoder with the parser state.
    pfw_decode #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_byte    (i_s_axis_tdata),
        .i_in_last    (i_s_axis_tlast),
        .o_pair_valid (pair_valid),
        .i_pair_ready (pair_ready),
        .o_pair       (pair)
    );

    // Result queue, one event per item on the output.
    pfw_out_queue u_out_queue (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_pair_valid    (pair_valid),
        .o_pair_ready    (pair_ready),
        .i_pair          (pair),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
